>>> hdl/ovmt_pkg.sv
// Shared types and codes for the offset vote match table.
// No dependencies; every other file imports this package.
package ovmt_pkg;

  typedef enum logic [1:0] {
    ACT_TALLY  = 2'd0,
    ACT_AGE    = 2'd1,
    ACT_REPORT = 2'd2,
    ACT_NONE   = 2'd3
  } act_t;

  typedef enum logic [7:0] {
    REG_MAX_AGE   = 8'd0,
    REG_MIN_COUNT = 8'd1,
    REG_LIMIT     = 8'd2,
    REG_MIN_SPAN  = 8'd3
  } reg_idx_t;

  typedef struct packed {
    act_t        act;
    logic [31:0] qt;
    logic [31:0] rt;
    logic [31:0] id;
    logic [32:0] key;
  } cmd_t;

  typedef struct packed {
    logic [31:0] max_age;
    logic [15:0] min_count;
    logic [6:0]  limit;
    logic [31:0] min_span;
  } cfg_t;

  typedef struct packed {
    logic [15:0] votes;
    logic [31:0] id;
    logic [31:0] first;
    logic [31:0] last;
    logic [32:0] offset;
    logic        last_flag;
    logic        ovf;
  } res_t;

endpackage

>>> hdl/offset_vote_match_table_top.sv
// Offset vote match table. The sequencer takes one item at a time. A tally or an age-out
// walks the whole table once through a single-port read of the entry memory and takes
// no new item until the walk is done. A report makes one walk per selected entry, plus
// one walk that finds none when fewer than min(limit, MAX_REPORTED) entries qualify.
// A limit of 0 makes no walk. A full result queue stalls the report. An age-out with
// max_age 0 makes no walk, and action 3 is dropped at the input. Items queue two deep
// ahead of the sequencer and results two deep behind it. No clearing pass follows reset.
// Write registers through cfg_valid/cfg_ready only while no item is in flight.
// Depends on ovmt_pkg, ovmt_front, ovmt_engine and ovmt_rq.
module offset_vote_match_table_top #(
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_REPORTED  = 64,
  parameter int OFFSET_SHIFT  = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [31:0] query_time,
  input  logic [31:0] ref_time,
  input  logic [31:0] ref_id,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] vote_count,
  output logic [31:0] match_ref,
  output logic [31:0] span_first,
  output logic [31:0] span_last,
  output logic signed [32:0] time_offset,
  output logic        last_flag,
  output logic        overflow_seen,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ovmt_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;
  logic res_push;
  logic res_full;
  res_t res_in;
  res_t res_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_age   <= 32'd0;
      cfg.min_count <= 16'd5;
      cfg.limit     <= 7'd10;
      cfg.min_span  <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_MAX_AGE:   cfg.max_age   <= cfg_data;
        REG_MIN_COUNT: cfg.min_count <= cfg_data[15:0];
        REG_LIMIT:     cfg.limit     <= cfg_data[6:0];
        REG_MIN_SPAN:  cfg.min_span  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ovmt_front #(.OFFSET_SHIFT(OFFSET_SHIFT)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action),
    .query_time(query_time), .ref_time(ref_time), .ref_id(ref_id),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  ovmt_engine #(
    .TABLE_ENTRIES(TABLE_ENTRIES), .MAX_REPORTED(MAX_REPORTED),
    .OFFSET_SHIFT(OFFSET_SHIFT)
  ) u_engine (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd), .cfg(cfg), .res_push(res_push), .res(res_in), .res_full(res_full)
  );

  ovmt_rq u_rq (
    .clk(clk), .rst(rst), .wr(res_push), .wd(res_in), .full(res_full),
    .empty(empty), .pop(pop), .rd(res_out)
  );

  assign vote_count    = res_out.votes;
  assign match_ref     = res_out.id;
  assign span_first    = res_out.first;
  assign span_last     = res_out.last;
  assign time_offset   = $signed(res_out.offset);
  assign last_flag     = res_out.last_flag;
  assign overflow_seen = res_out.ovf;

endmodule

>>> hdl/ovmt_front.sv
// Front end: two-word input queue that classifies items and forms the offset key.
// Depends on ovmt_pkg.
module ovmt_front #(
  parameter int OFFSET_SHIFT = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          action,
  input  logic [31:0]         query_time,
  input  logic [31:0]         ref_time,
  input  logic [31:0]         ref_id,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output ovmt_pkg::cmd_t      cmd
);
  import ovmt_pkg::*;

  cmd_t        q [2];
  logic        wp;
  logic        rp;
  logic [1:0]  cnt;
  logic        enq;
  logic        deq;
  logic [32:0] diff;
  cmd_t        in_cmd;

  assign diff = {1'b0, query_time} - {1'b0, ref_time};
  assign in_cmd.act = act_t'(action);
  assign in_cmd.qt  = query_time;
  assign in_cmd.rt  = ref_time;
  assign in_cmd.id  = ref_id;
  assign in_cmd.key = 33'($signed(diff) >>> OFFSET_SHIFT);

  assign full      = (cnt == 2'd2);
  assign enq       = push && !full && (act_t'(action) != ACT_NONE);
  assign cmd_valid = (cnt != 2'd0);
  assign deq       = cmd_valid && cmd_ready;
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wp] <= in_cmd;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (enq) wp <= ~wp;
      if (deq) rp <= ~rp;
      cnt <= cnt + 2'(enq) - 2'(deq);
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    full |=> cnt != 2'd3) else $error("input queue overfilled");
  a_deq_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0) |-> !deq) else $error("dequeue from empty queue");
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (enq && !deq) |=> cnt == $past(cnt) + 2'd1) else $error("count slip");
`endif

endmodule

>>> hdl/ovmt_engine.sv
// Back end: vote table memory with valid flags and the tally, age-out and report sequencer.
// Depends on ovmt_pkg.
module ovmt_engine #(
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_REPORTED  = 64,
  parameter int OFFSET_SHIFT  = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  ovmt_pkg::cmd_t  cmd,
  input  ovmt_pkg::cfg_t  cfg,
  output logic            res_push,
  output ovmt_pkg::res_t  res,
  input  logic            res_full
);
  import ovmt_pkg::*;

  localparam int AW    = $clog2(TABLE_ENTRIES);
  localparam int KEY_W = 33 - OFFSET_SHIFT;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [31:0]      id;
    logic [31:0]      qt;
    logic [31:0]      rt;
    logic [31:0]      first;
    logic [31:0]      last;
    logic [15:0]      votes;
  } ent_t;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_END, S_DONE} state_t;

  ent_t        mem [TABLE_ENTRIES];
  ent_t        rd_q;
  logic [AW-1:0] rd_addr;
  logic        we;
  logic [AW-1:0] wa;
  ent_t        wd;

  logic [TABLE_ENTRIES-1:0] valid;
  logic [TABLE_ENTRIES-1:0] picked;
  logic        ovf;

  state_t      state;
  cmd_t        cur;
  logic [AW:0] cnt;
  logic        p_v;
  logic [AW-1:0] p_idx;
  logic        hit;
  ent_t        hit_ent;
  logic [AW-1:0] hit_idx;
  logic        free_v;
  logic [AW-1:0] free_idx;
  logic        best_v;
  ent_t        best;
  logic [AW-1:0] best_idx;
  logic        pend_v;
  ent_t        pend;
  logic [6:0]  pass;
  logic [6:0]  lim;

  logic        issue;
  logic        key_eq;
  logic signed [32:0] age;
  logic        aged;
  logic        cand;
  logic        span_ok;
  logic [15:0] votes_inc;
  ent_t        upd;
  ent_t        fresh;
  ent_t        src;
  logic        src_v;
  logic        src_last;

  assign lim = (cfg.limit > 7'(MAX_REPORTED)) ? 7'(MAX_REPORTED) : cfg.limit;
  assign cmd_ready = (state == S_IDLE);
  assign issue = (state == S_SCAN) && (cnt != (AW+1)'(TABLE_ENTRIES));
  assign rd_addr = cnt[AW-1:0];

  assign key_eq = (rd_q.key == cur.key[KEY_W-1:0]) && (rd_q.id == cur.id);
  assign age    = $signed({1'b0, cur.qt}) - $signed({1'b0, rd_q.qt});
  assign aged   = age > $signed({1'b0, cfg.max_age});
  assign cand   = valid[p_idx] && !picked[p_idx] && (rd_q.votes >= cfg.min_count);
  assign span_ok = (best.last - best.first) >= cfg.min_span;

  assign votes_inc = (hit_ent.votes == 16'hFFFF) ? hit_ent.votes : hit_ent.votes + 16'd1;
  always_comb begin
    upd       = hit_ent;
    upd.qt    = cur.qt;
    upd.rt    = cur.rt;
    upd.votes = votes_inc;
    if (cur.rt < hit_ent.first) upd.first = cur.rt;
    if (cur.rt > hit_ent.last)  upd.last  = cur.rt;
    fresh.key   = cur.key[KEY_W-1:0];
    fresh.id    = cur.id;
    fresh.qt    = cur.qt;
    fresh.rt    = cur.rt;
    fresh.first = cur.rt;
    fresh.last  = cur.rt;
    fresh.votes = 16'd1;
  end

  always_comb begin
    we = 1'b0;
    wa = free_idx;
    wd = fresh;
    if (state == S_END && cur.act == ACT_TALLY) begin
      if (hit) begin
        we = 1'b1;
        wa = hit_idx;
        wd = upd;
      end else if (free_v) begin
        we = 1'b1;
      end
    end
  end

  always_comb begin
    res_push = 1'b0;
    src      = pend;
    src_v    = pend_v;
    src_last = 1'b0;
    if (state == S_END && cur.act == ACT_REPORT && best_v && span_ok && pend_v
        && !res_full) begin
      res_push = 1'b1;
    end
    if (state == S_DONE && !res_full) begin
      res_push = 1'b1;
      src_last = 1'b1;
    end
    if (src_v) begin
      res.votes  = src.votes;
      res.id     = src.id;
      res.first  = src.first;
      res.last   = src.last;
      res.offset = {1'b0, src.qt} - {1'b0, src.rt};
    end else begin
      res.votes  = '0;
      res.id     = '0;
      res.first  = '0;
      res.last   = '0;
      res.offset = '0;
    end
    res.last_flag = src_last;
    res.ovf       = ovf;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      valid  <= '0;
      picked <= '0;
      ovf    <= 1'b0;
      p_v    <= 1'b0;
      cnt    <= '0;
      hit    <= 1'b0;
      free_v <= 1'b0;
      best_v <= 1'b0;
      pend_v <= 1'b0;
      pass   <= '0;
    end else begin
      p_v   <= issue;
      p_idx <= cnt[AW-1:0];
      if (issue) cnt <= cnt + 1'b1;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur    <= cmd;
            cnt    <= '0;
            hit    <= 1'b0;
            free_v <= 1'b0;
            best_v <= 1'b0;
            pend_v <= 1'b0;
            pass   <= '0;
            picked <= '0;
            if (cmd.act == ACT_AGE && cfg.max_age == 32'd0) begin
              state <= S_IDLE;
            end else if (cmd.act == ACT_REPORT && lim == 7'd0) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (p_v) begin
            case (cur.act)
              ACT_TALLY: begin
                if (valid[p_idx]) begin
                  if (key_eq) begin
                    hit     <= 1'b1;
                    hit_ent <= rd_q;
                    hit_idx <= p_idx;
                  end
                end else if (!free_v) begin
                  free_v   <= 1'b1;
                  free_idx <= p_idx;
                end
              end
              ACT_AGE: begin
                if (valid[p_idx] && aged) valid[p_idx] <= 1'b0;
              end
              ACT_REPORT: begin
                if (cand && (!best_v || rd_q.votes > best.votes)) begin
                  best_v   <= 1'b1;
                  best     <= rd_q;
                  best_idx <= p_idx;
                end
              end
              default: begin
              end
            endcase
          end
          if (!issue && !p_v) state <= S_END;
        end
        S_END: begin
          case (cur.act)
            ACT_TALLY: begin
              if (!hit && free_v) valid[free_idx] <= 1'b1;
              if (!hit && !free_v) ovf <= 1'b1;
              state <= S_IDLE;
            end
            ACT_REPORT: begin
              if (!best_v) begin
                state <= S_DONE;
              end else if (!(span_ok && pend_v && res_full)) begin
                picked[best_idx] <= 1'b1;
                if (span_ok) begin
                  pend   <= best;
                  pend_v <= 1'b1;
                end
                pass   <= pass + 7'd1;
                best_v <= 1'b0;
                cnt    <= '0;
                if (pass + 7'd1 == lim) state <= S_DONE;
                else state <= S_SCAN;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_DONE: begin
          if (!res_full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_push_space: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full) else $error("result pushed into full queue");
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(ovf) |-> ovf) else $error("overflow flag cleared");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !issue && !we) else $error("table access while idle");
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.last_flag) |=> state == S_IDLE) else $error("report end slip");
`endif

endmodule

>>> hdl/ovmt_rq.sv
// Two-word result queue between the table sequencer and the result ports.
// Depends on ovmt_pkg.
module ovmt_rq (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  ovmt_pkg::res_t  wd,
  output logic            full,
  output logic            empty,
  input  logic            pop,
  output ovmt_pkg::res_t  rd
);
  import ovmt_pkg::*;

  res_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       deq;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign deq   = pop && !empty;
  assign rd    = q[rp];

  always_ff @(posedge clk) begin
    if (wr) q[wp] <= wd;
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr)  wp <= ~wp;
      if (deq) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(deq);
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    full |-> !wr) else $error("result queue overfilled");
  a_cnt_drop: assert property (@(posedge clk) disable iff (rst)
    (deq && !wr) |=> cnt == $past(cnt) - 2'd1) else $error("count slip");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (wr && !deq) |=> !empty) else $error("written word lost");
`endif

endmodule

>>> sim/testbench.sv
// Self-checking bench for offset_vote_match_table_top: a scoreboard class models the
// vote table and checks every result word; plain tasks drive items and registers.
// Depends on ovmt_pkg and the RTL under hdl.
`timescale 1ns / 100ps

module testbench;
  import ovmt_pkg::*;

  localparam int SLOTS      = 256;
  localparam int MAX_REP    = 64;
  localparam int SHIFT      = 2;
  localparam int DRAIN      = 1200;
  localparam int CYCLE_CAP  = 10000000;

  class vote_scoreboard;
    bit          live [SLOTS];
    logic [32:0] okey [SLOTS];
    logic [31:0] rid [SLOTS];
    logic [31:0] qlast [SLOTS];
    logic [31:0] rlast [SLOTS];
    logic [31:0] sfirst [SLOTS];
    logic [31:0] slast [SLOTS];
    logic [15:0] votes [SLOTS];
    bit          ovf;
    logic [31:0] max_age;
    logic [15:0] min_count;
    logic [6:0]  limit;
    logic [31:0] min_span;
    res_t        pending [$];
    int          errors;

    function new();
      for (int i = 0; i < SLOTS; i++) live[i] = 0;
      ovf = 0;
      max_age = 0;
      min_count = 5;
      limit = 10;
      min_span = 0;
      errors = 0;
    endfunction

    task mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_MAX_AGE:   max_age = val;
        REG_MIN_COUNT: min_count = val[15:0];
        REG_LIMIT:     limit = val[6:0];
        REG_MIN_SPAN:  min_span = val;
        default: ;
      endcase
    endfunction

    function void tally(logic [31:0] q, logic [31:0] r, logic [31:0] id);
      logic signed [32:0] d;
      logic [32:0] k;
      int slot;
      d = {1'b0, q} - {1'b0, r};
      k = d >>> SHIFT;
      slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (live[i]) begin
          if (okey[i] == k && rid[i] == id) begin
            qlast[i] = q;
            rlast[i] = r;
            if (votes[i] != 16'hFFFF) votes[i]++;
            if (r < sfirst[i]) sfirst[i] = r;
            if (r > slast[i]) slast[i] = r;
            return;
          end
        end else if (slot < 0) begin
          slot = i;
        end
      end
      if (slot < 0) begin
        ovf = 1;
        return;
      end
      live[slot] = 1;
      okey[slot] = k;
      rid[slot] = id;
      qlast[slot] = q;
      rlast[slot] = r;
      sfirst[slot] = r;
      slast[slot] = r;
      votes[slot] = 1;
    endfunction

    function void age_out(logic [31:0] now);
      longint a;
      if (max_age == 0) return;
      for (int i = 0; i < SLOTS; i++) begin
        a = longint'({32'd0, now}) - longint'({32'd0, qlast[i]});
        if (live[i] && a > longint'({32'd0, max_age})) live[i] = 0;
      end
    endfunction

    function void report();
      bit   taken [SLOTS];
      int   lim, best, n;
      res_t w;
      lim = (limit > MAX_REP) ? MAX_REP : limit;
      n = 0;
      for (int i = 0; i < SLOTS; i++) taken[i] = 0;
      for (int k = 0; k < lim; k++) begin
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (!live[i] || taken[i] || votes[i] < min_count) continue;
          if (best < 0 || votes[i] > votes[best]) best = i;
        end
        if (best < 0) break;
        taken[best] = 1;
        if (slast[best] - sfirst[best] >= min_span) begin
          w.votes = votes[best];
          w.id = rid[best];
          w.first = sfirst[best];
          w.last = slast[best];
          w.offset = {1'b0, qlast[best]} - {1'b0, rlast[best]};
          w.last_flag = 0;
          w.ovf = ovf;
          pending.push_back(w);
          n++;
        end
      end
      if (n == 0) begin
        w = '0;
        w.ovf = ovf;
        pending.push_back(w);
      end
      pending[pending.size() - 1].last_flag = 1;
    endfunction

    function void note(act_t act, logic [31:0] q, logic [31:0] r, logic [31:0] id);
      case (act)
        ACT_TALLY:  tally(q, r, id);
        ACT_AGE:    age_out(q);
        ACT_REPORT: report();
        default: ;
      endcase
    endfunction

    task check(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        mismatch($sformatf("unexpected word votes=%0d id=%h", got.votes, got.id));
        return;
      end
      e = pending.pop_front();
      if (got.votes !== e.votes)
        mismatch($sformatf("vote_count %0d, want %0d", got.votes, e.votes));
      if (got.id !== e.id) mismatch($sformatf("match_ref %h, want %h", got.id, e.id));
      if (got.first !== e.first)
        mismatch($sformatf("span_first %h, want %h", got.first, e.first));
      if (got.last !== e.last)
        mismatch($sformatf("span_last %h, want %h", got.last, e.last));
      if (got.offset !== e.offset)
        mismatch($sformatf("time_offset %h, want %h", got.offset, e.offset));
      if (got.last_flag !== e.last_flag)
        mismatch($sformatf("last_flag %b, want %b", got.last_flag, e.last_flag));
      if (got.ovf !== e.ovf)
        mismatch($sformatf("overflow_seen %b, want %b", got.ovf, e.ovf));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic full;
  logic [1:0] action = ACT_NONE;
  logic [31:0] query_time = 0, ref_time = 0, ref_id = 0;
  logic empty;
  logic pop = 0;
  logic [15:0] vote_count;
  logic [31:0] match_ref, span_first, span_last;
  logic signed [32:0] time_offset;
  logic last_flag, overflow_seen;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [7:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  vote_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  bit hold = 0;
  int cycles = 0;
  logic [31:0] now = 32'd1000;

  offset_vote_match_table_top DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action),
    .query_time(query_time), .ref_time(ref_time), .ref_id(ref_id),
    .empty(empty), .pop(pop), .vote_count(vote_count), .match_ref(match_ref),
    .span_first(span_first), .span_last(span_last), .time_offset(time_offset),
    .last_flag(last_flag), .overflow_seen(overflow_seen),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (!rst && pop && !empty) begin
      got.votes = vote_count;
      got.id = match_ref;
      got.first = span_first;
      got.last = span_last;
      got.offset = time_offset;
      got.last_flag = last_flag;
      got.ovf = overflow_seen;
      sb.check(got);
    end
    pop <= !hold && ($urandom_range(99) >= recv_stall);
  end

  task automatic send(act_t act, logic [31:0] q, logic [31:0] r, logic [31:0] id);
    while ($urandom_range(99) < send_idle) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    action <= act;
    query_time <= q;
    ref_time <= r;
    ref_id <= id;
    do @(posedge clk); while (full);
    sb.note(act, q, r, id);
  endtask

  task automatic settle();
    push <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic configure(logic [31:0] age, logic [15:0] cnt, logic [6:0] lim,
                           logic [31:0] span);
    settle();
    write_reg(REG_MAX_AGE, age);
    write_reg(REG_MIN_COUNT, cnt);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_MIN_SPAN, span);
  endtask

  task automatic random_items(int count);
    int pick;
    logic [31:0] r, off;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      now = now + $urandom_range(6);
      if (pick < 78) begin
        off = 32'd500 * $urandom_range(3) + $urandom_range(5);
        r = now - off + $urandom_range(40);
        send(ACT_TALLY, r + off, r, 32'd10 + $urandom_range(3));
      end else if (pick < 86) begin
        send(ACT_REPORT, $urandom, $urandom, $urandom);
      end else if (pick < 91) begin
        send(ACT_AGE, now, $urandom, $urandom);
      end else begin
        send(act_t'($urandom_range(3)), $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(ACT_REPORT, 0, 0, 0);
    send(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ACT_TALLY, 0, 0, 0);
    send(ACT_TALLY, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    send(ACT_TALLY, 0, 32'hFFFF_FFFF, 5);
    send(ACT_TALLY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    for (int i = 0; i < 6; i++) send(ACT_TALLY, 100 + 3 * i, 10 + 3 * i, 7);
    for (int i = 0; i < 5; i++) send(ACT_TALLY, 201 + i, 5 + i, 9);
    send(ACT_TALLY, 3, 6, 5);
    send(ACT_REPORT, 0, 0, 0);
    send(ACT_AGE, 32'd5000, 0, 0);
    configure(32'd50, 16'd1, 7'd10, 32'd0);
    send(ACT_AGE, 32'd0, 0, 0);
    send(ACT_REPORT, 0, 0, 0);
    send(ACT_AGE, 32'd190, 0, 0);
    send(ACT_REPORT, 0, 0, 0);

    configure(32'd0, 16'd2, 7'd5, 32'd0);
    random_items(18);
    send_idle = 82;
    configure(32'd0, 16'd1, 7'd64, 32'hFFFF_FFFF);
    random_items(18);
    send_idle = 0;
    recv_stall = 82;
    configure(32'hFFFF_FFFF, 16'hFFFF, 7'd1, 32'd4);
    random_items(18);
    send_idle = 31;
    recv_stall = 31;
    configure(32'd200, 16'd3, 7'd100, 32'd2);
    random_items(8);
    configure(32'd300, 16'd1, 7'd0, 32'd0);
    random_items(8);

    send_idle = 0;
    recv_stall = 0;
    configure(32'd400, 16'd1, 7'd3, 32'd0);
    fork
      begin
        hold = 1;
        repeat (20000) @(posedge clk);
        hold = 0;
      end
    join_none
    for (int i = 0; i < 8; i++) send(ACT_REPORT, 0, 0, 0);

    configure(32'd1, 16'd1, 7'd64, 32'd0);
    send(ACT_AGE, now + 32'd100, 0, 0);
    for (int i = 0; i < 4; i++) send(ACT_TALLY, now + i, now, 32'd1000 + i);
    send(ACT_REPORT, 0, 0, 0);

    settle();
    if (sb.pending.size() != 0) sb.mismatch("expected words left over");
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
